/* design/cla_pkg.sv */
// Shared types, codes and constants for the command line assembler.
`default_nettype none

package cla_pkg;

	localparam int CLA_DEPTH = 64;     // default ring depth
	localparam int LINE_CAP  = 64;     // line store entries
	localparam int LINE_AW   = 6;      // line store address width
	localparam int RES_CNT_W = 6;      // counts up to 64 echoes per poll

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POLL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic emit_direct;   // single result formed from the accepted transaction
		logic do_push;       // store rx byte unless ring is full
		logic start_scan;    // poll with bytes pending
		logic scan_step;     // consume one ring byte into the output register
		logic start_read;    // capture line store entry
		logic read_resp;     // emit the captured line byte
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;      // output register can take a result this cycle
		logic scan_empty;    // nothing unscanned
		logic scan_stop;     // current scan byte is the final result of the poll
	} stat_t;

endpackage

`default_nettype wire

/* design/cla_ctrl.sv */
// Controller state machine for the command line assembler.
`default_nettype none

module cla_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  cla_pkg::cmd_t  cmd,
	input  cla_pkg::stat_t stat,
	output logic           in_ready,
	output cla_pkg::ctrl_t ctrl
);
	import cla_pkg::*;

	state_t state_q, state_nx;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_ready && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_POLL && !stat.scan_empty)
						state_nx = ST_SCAN;
					else if (cmd == CMD_READ)
						state_nx = ST_READ;
				end
			end
			ST_SCAN: begin
				if (stat.out_free && stat.scan_stop)
					state_nx = ST_IDLE;
			end
			ST_READ: begin
				if (stat.out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_PUSH: begin
							ctrl.do_push     = 1'b1;
							ctrl.emit_direct = 1'b1;
						end
						CMD_POLL: begin
							if (stat.scan_empty)
								ctrl.emit_direct = 1'b1;
							else
								ctrl.start_scan = 1'b1;
						end
						CMD_READ: ctrl.start_read = 1'b1;
						default:  ctrl.emit_direct = 1'b1;
					endcase
				end
			end
			ST_SCAN: ctrl.scan_step = stat.out_free;
			ST_READ: ctrl.read_resp = stat.out_free;
			default: ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

/* design/cla_dpath.sv */
// Datapath: receive ring, counters, line store and output register.
`default_nettype none

module cla_dpath #(
	parameter int DEPTH = cla_pkg::CLA_DEPTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  cla_pkg::ctrl_t              ctrl,
	output cla_pkg::stat_t              stat,
	input  wire [7:0]                   rx_byte,
	input  wire [cla_pkg::LINE_AW-1:0]  line_index,
	input  wire                         out_ready,
	output logic                        out_valid,
	output logic                        out_data_valid,
	output logic [7:0]                  out_data,
	output logic                        out_line_found,
	output logic                        out_dropped,
	output logic                        out_last
);
	import cla_pkg::*;

	localparam int SPAN  = 2 * DEPTH;
	localparam int CNT_W = $clog2(SPAN);
	localparam int AW    = $clog2(DEPTH);
	localparam int LP_W  = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] slot_of(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] s;
		s = (c >= CNT_W'(DEPTH)) ? c - CNT_W'(DEPTH) : c;
		return s[AW-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] inc_of(input logic [CNT_W-1:0] c);
		return (c == CNT_W'(SPAN - 1)) ? '0 : c + 1'b1;
	endfunction

	// ring and counters
	logic [7:0]         ring_mem [DEPTH];
	logic [7:0]         ring_rd_q;
	logic [CNT_W-1:0]   wr_cnt_q, scan_cnt_q, start_cnt_q;
	logic [LP_W-1:0]    line_pos_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	// line store
	logic [7:0]         line_mem [LINE_CAP];
	logic [LINE_CAP-1:0] line_vld_q;
	logic [7:0]         line_rd_q;
	logic               line_rd_vld_q;

	// output register
	logic               out_valid_q, dv_q, lf_q, dr_q, last_q;
	logic [7:0]         data_q;

	logic [CNT_W-1:0]   fill;
	logic               ring_full;
	logic [CNT_W-1:0]   scan_nx;
	logic [AW-1:0]      rd_slot;
	logic [7:0]         ch;
	logic               is_term, is_bs, term_ok, line_wr, scan_last;
	logic [LP_W-1:0]    line_pos_nx;
	logic               ld;

	assign fill      = (wr_cnt_q >= start_cnt_q) ? wr_cnt_q - start_cnt_q
	                                             : wr_cnt_q - start_cnt_q + CNT_W'(SPAN);
	assign ring_full = fill >= CNT_W'(DEPTH);

	assign scan_nx = inc_of(scan_cnt_q);
	assign rd_slot = ctrl.scan_step ? slot_of(scan_nx) : slot_of(scan_cnt_q);

	assign ch      = ring_rd_q;
	assign is_term = (ch == CH_LF) || (ch == CH_CR);
	assign is_bs   = (ch == CH_BS);
	assign term_ok = is_term && (line_pos_q < LP_W'(DEPTH - 1));
	assign line_wr = ctrl.scan_step &&
	                 (term_ok || (!is_term && !is_bs && line_pos_q < LP_W'(DEPTH)));
	assign scan_last = term_ok || (scan_nx == wr_cnt_q) ||
	                   (res_cnt_q == {RES_CNT_W{1'b1}});

	always_comb begin
		if (is_term)
			line_pos_nx = '0;
		else if (is_bs)
			line_pos_nx = (line_pos_q != '0) ? line_pos_q - 1'b1 : line_pos_q;
		else if (line_pos_q < LP_W'(DEPTH))
			line_pos_nx = line_pos_q + 1'b1;
		else
			line_pos_nx = line_pos_q;
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.scan_empty = (scan_cnt_q == wr_cnt_q);
	assign stat.scan_stop  = scan_last;

	assign ld = ctrl.emit_direct || ctrl.scan_step || ctrl.read_resp;

	// ring memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (ctrl.do_push && !ring_full)
			ring_mem[slot_of(wr_cnt_q)] <= rx_byte;
		ring_rd_q <= ring_mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q    <= '0;
			scan_cnt_q  <= '0;
			start_cnt_q <= '0;
			line_pos_q  <= '0;
			res_cnt_q   <= '0;
		end else begin
			if (ctrl.do_push && !ring_full)
				wr_cnt_q <= inc_of(wr_cnt_q);
			if (ctrl.start_scan)
				res_cnt_q <= '0;
			if (ctrl.scan_step) begin
				scan_cnt_q <= scan_nx;
				line_pos_q <= line_pos_nx;
				res_cnt_q  <= res_cnt_q + 1'b1;
				if (is_term)
					start_cnt_q <= scan_nx;
			end
		end
	end

	// line store; entries never written read as zero
	always_ff @(posedge clk) begin
		if (line_wr)
			line_mem[LINE_AW'(line_pos_q)] <= ch;
		if (ctrl.start_read)
			line_rd_q <= line_mem[line_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q    <= '0;
			line_rd_vld_q <= 1'b0;
		end else begin
			if (line_wr)
				line_vld_q[LINE_AW'(line_pos_q)] <= 1'b1;
			if (ctrl.start_read)
				line_rd_vld_q <= line_vld_q[line_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			if (ctrl.scan_step) begin
				dv_q   <= 1'b1;
				data_q <= ch;
				lf_q   <= term_ok;
				dr_q   <= 1'b0;
				last_q <= scan_last;
			end else if (ctrl.read_resp) begin
				dv_q   <= 1'b1;
				data_q <= line_rd_vld_q ? line_rd_q : 8'h00;
				lf_q   <= 1'b0;
				dr_q   <= 1'b0;
				last_q <= 1'b1;
			end else begin
				dv_q   <= 1'b0;
				data_q <= 8'h00;
				lf_q   <= 1'b0;
				dr_q   <= ctrl.do_push && ring_full;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data_valid = dv_q;
	assign out_data       = data_q;
	assign out_line_found = lf_q;
	assign out_dropped    = dr_q;
	assign out_last       = last_q;

endmodule

`default_nettype wire

/* design/command_line_assembler.sv */
// Push, no-op and empty poll give one result, registered in the cycle after acceptance.
// A read answers through the registered line store port and then the output register.
// A poll with bytes pending echoes its first byte through the registered read port of the
// receive ring, then one echo per cycle while the output register is free, paced by that port.
// One command is in progress at a time; the next is taken after the last result is loaded.
// Reset clears counters, line position, line store valid bits and output valid; not the ring.
`default_nettype none

module command_line_assembler #(
	parameter int DEPTH = cla_pkg::CLA_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [7:0] rx_byte, [13:8] line_index, [15:14] zero
	input  wire  [1:0]  s_tuser,   // [1:0] cmd
	input  wire         s_tlast,   // end_of_packet, framing only
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [7:0] data, [8] line_found, [9] dropped, [15:10] zero
	output logic        m_tuser,   // [0] data_valid
	output logic        m_tlast    // last result of the command
);
	import cla_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	cmd_t  cmd;
	logic  line_found, dropped;
	logic [7:0] data;
	logic  eop_unused;

	assign cmd        = cmd_t'(s_tuser);
	assign eop_unused = s_tlast;

	cla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.cmd      (cmd),
		.stat     (stat),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	cla_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.rx_byte        (s_tdata[7:0]),
		.line_index     (s_tdata[13:8]),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_data_valid (m_tuser),
		.out_data       (data),
		.out_line_found (line_found),
		.out_dropped    (dropped),
		.out_last       (m_tlast)
	);

	assign m_tdata = {6'b0, dropped, line_found, data};

endmodule

`default_nettype wire

/* verif/command_line_assembler_checker.sv */
`timescale 1ns / 1ps
// Checker for the command line assembler: mirrors its line state and compares every result.
module command_line_assembler_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] rx_byte, [13:8] line_index, [15:14] zero
	input  logic [1:0]  s_tuser,    // [1:0] cmd
	input  logic        s_tlast,    // end_of_packet
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,    // [7:0] data, [8] line_found, [9] dropped, [15:10] zero
	input  logic        m_tuser,    // [0] data_valid
	input  logic        m_tlast,
	output int          errors,
	output int          backlog,
	output logic [6:0]  unbroken_run  // stored bytes since the last stored CR/LF
);
	import cla_pkg::*;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data;
		logic       line_found;
		logic       dropped;
		logic       last;
	} line_result_t;

	line_result_t line_results[$];

	// ring index is the low six counter bits: the block runs at the default depth of 64
	logic [7:0] ring_mirror [64];
	logic [7:0] line_mirror [LINE_CAP];
	logic [6:0] wr_cnt;
	logic [6:0] scan_cnt;
	logic [6:0] line_start;
	logic [6:0] line_pos;

	function automatic bit is_eol(input logic [7:0] ch);
		return ch == CH_CR || ch == CH_LF;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic assemble_step(input cmd_t cmd, input logic [7:0] rx, input logic [5:0] idx);
		line_result_t r;
		logic [7:0] ch;
		int n;
		bit stop;
		r = '0;
		r.last = 1'b1;
		n = 0;
		stop = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				// counters wrap at 2*DEPTH, so a 7-bit difference is the ring fill
				if (7'(wr_cnt - line_start) >= 7'(CLA_DEPTH)) begin
					r.dropped = 1'b1;
				end else begin
					ring_mirror[wr_cnt[5:0]] = rx;
					wr_cnt++;
					unbroken_run = is_eol(rx) ? 7'd0 : unbroken_run + 7'd1;
				end
				line_results.push_back(r);
			end
			CMD_POLL: begin
				while (!stop && scan_cnt != wr_cnt && n < 64) begin
					ch = ring_mirror[scan_cnt[5:0]];
					scan_cnt++;
					r = '0;
					r.data_valid = 1'b1;
					r.data = ch;
					r.last = (scan_cnt == wr_cnt) || (n == 63);
					if (is_eol(ch)) begin
						line_start = scan_cnt;
						// an overlong line is dropped and the scan carries on
						if (line_pos < 7'(CLA_DEPTH - 1)) begin
							line_mirror[line_pos[5:0]] = ch;
							r.line_found = 1'b1;
							r.last = 1'b1;
							stop = 1'b1;
						end
						line_pos = '0;
					end else if (ch == CH_BS) begin
						if (line_pos != 0)
							line_pos--;
					end else if (line_pos < 7'(CLA_DEPTH)) begin
						line_mirror[line_pos[5:0]] = ch;
						line_pos++;
					end
					line_results.push_back(r);
					n++;
				end
				if (n == 0)
					line_results.push_back(r);
			end
			CMD_READ: begin
				r.data_valid = 1'b1;
				r.data = line_mirror[idx];
				line_results.push_back(r);
			end
			default: begin
				line_results.push_back(r);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		line_result_t want;
		if (!arst_n) begin
			line_results.delete();
			wr_cnt = '0;
			scan_cnt = '0;
			line_start = '0;
			line_pos = '0;
			unbroken_run = '0;
			for (int i = 0; i < LINE_CAP; i++)
				line_mirror[i] = '0;
		end else begin
			// results leave before the transaction taken on the same edge can produce any
			if (m_tvalid && m_tready) begin
				if (line_results.size() == 0) begin
					$error("result with nothing outstanding: data %0h, last %0b",
						m_tdata[7:0], m_tlast);
					errors++;
				end else begin
					want = line_results.pop_front();
					compare_field("data_valid", want.data_valid, m_tuser);
					compare_field("data", want.data, m_tdata[7:0]);
					compare_field("line_found", want.line_found, m_tdata[8]);
					compare_field("dropped", want.dropped, m_tdata[9]);
					compare_field("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				assemble_step(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[13:8]);
		end
		backlog = line_results.size();
	end

endmodule

/* verif/command_line_assembler_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the command line assembler: stimulus, flow control and verdict.
module command_line_assembler_tb;
	import cla_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 100;
	localparam int RUN_GUARD   = 56;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] rx_byte, [13:8] line_index, [15:14] zero
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        s_tlast;   // end_of_packet
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] data, [8] line_found, [9] dropped, [15:10] zero
	logic        m_tuser;   // [0] data_valid
	logic        m_tlast;

	int         errors;
	int         backlog;
	logic [6:0] unbroken_run;
	int         idle_pct;
	int         stall_pct;
	bit         hold_go;
	int         sent;
	int         quiet;
	int         idle_pct_tab [4] = '{0, 51, 0, 16};
	int         stall_pct_tab[4] = '{0, 0, 51, 16};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	command_line_assembler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	command_line_assembler_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.errors       (errors),
		.backlog      (backlog),
		.unbroken_run (unbroken_run)
	);

	// result side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("** command_line_assembler: FAILED **");
			$finish;
		end
	end

	// One transaction on the input side. With guard set, a push that would let a run
	// without CR/LF fill the ring is turned into CR, since such a ring never drains.
	task automatic offer(input cmd_t cmd, input logic [7:0] b, input logic [5:0] idx,
			input bit guard);
		logic [7:0] rx;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		rx = b;
		if (guard && cmd == CMD_PUSH && unbroken_run >= RUN_GUARD && rx != CH_CR && rx != CH_LF)
			rx = CH_CR;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, idx, rx};
		s_tlast  <= 1'($urandom_range(1));
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_line(input int len);
		logic [7:0] ch;
		int r;
		repeat (len) begin
			r = $urandom_range(99);
			if (r < 10)
				ch = CH_BS;
			else if (r < 15)
				ch = 8'($urandom);
			else
				ch = 8'($urandom_range(8'h20, 8'h7E));
			offer(CMD_PUSH, ch, 6'($urandom), 1'b1);
		end
		offer(CMD_PUSH, $urandom_range(1) ? CH_CR : CH_LF, 6'($urandom), 1'b1);
	endtask

	// near-full line: fills the ring, drops the extra bytes, and with 63 bytes
	// the line is too long and gets ignored
	task automatic send_long_line();
		int len;
		len = $urandom_range(61, 63);
		offer(CMD_PUSH, CH_LF, 6'($urandom), 1'b1);
		repeat (4) offer(CMD_POLL, 8'($urandom), 6'($urandom), 1'b1);
		repeat (len) offer(CMD_PUSH, 8'($urandom_range(8'h20, 8'h7E)), 6'($urandom), 1'b0);
		offer(CMD_PUSH, $urandom_range(1) ? CH_CR : CH_LF, 6'($urandom), 1'b0);
		repeat (3) offer(CMD_PUSH, 8'($urandom_range(8'h20, 8'h7E)), 6'($urandom), 1'b1);
		repeat (3) offer(CMD_POLL, 8'($urandom), 6'($urandom), 1'b1);
		offer(CMD_READ, 8'($urandom), 6'(len - 1), 1'b1);
	endtask

	initial begin : stimulus
		int target;
		int pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_PUSH;
		s_tlast  = 1'b0;
		hold_go  = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		quiet = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// cleared line store, empty poll, unused command
		offer(CMD_READ, 8'h00, 6'd0, 1'b0);
		offer(CMD_READ, 8'hFF, 6'd63, 1'b0);
		offer(CMD_POLL, 8'h00, 6'd0, 1'b0);
		offer(CMD_NOP, 8'hFF, 6'd63, 1'b0);
		// edit a line down to nothing, backspace at line start, then two short lines
		offer(CMD_PUSH, 8'h00, 6'd0, 1'b0);
		offer(CMD_PUSH, 8'hFF, 6'd63, 1'b0);
		offer(CMD_PUSH, CH_BS, 6'd0, 1'b0);
		offer(CMD_PUSH, 8'h41, 6'd0, 1'b0);
		offer(CMD_PUSH, CH_BS, 6'd0, 1'b0);
		offer(CMD_PUSH, CH_BS, 6'd0, 1'b0);
		offer(CMD_PUSH, CH_BS, 6'd0, 1'b0);
		offer(CMD_PUSH, 8'h7A, 6'd0, 1'b0);
		offer(CMD_PUSH, CH_CR, 6'd0, 1'b0);
		offer(CMD_PUSH, 8'h71, 6'd0, 1'b0);
		offer(CMD_PUSH, CH_LF, 6'd0, 1'b0);
		offer(CMD_POLL, 8'h00, 6'd0, 1'b0);
		offer(CMD_POLL, 8'h00, 6'd0, 1'b0);
		offer(CMD_POLL, 8'h00, 6'd0, 1'b0);
		offer(CMD_READ, 8'h00, 6'd0, 1'b0);
		offer(CMD_READ, 8'h00, 6'd1, 1'b0);
		offer(CMD_READ, 8'h00, 6'd2, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_pct_tab[ph];
			stall_pct = stall_pct_tab[ph];
			target = sent + PHASE_ITEMS;
			if (ph == 0)
				hold_go = 1'b1;
			if (ph % 2 == 0)
				send_long_line();
			while (sent < target) begin
				pick = $urandom_range(99);
				if (pick < 3) begin
					send_long_line();
				end else if (pick < 60) begin
					send_line($urandom_range(0, 24));
					repeat ($urandom_range(1, 2))
						offer(CMD_POLL, 8'($urandom), 6'($urandom), 1'b1);
					repeat ($urandom_range(0, 3))
						offer(CMD_READ, 8'($urandom), 6'($urandom_range(0, 15)), 1'b1);
				end else if (pick < 80) begin
					repeat ($urandom_range(1, 6))
						offer(cmd_t'($urandom_range(3)), 8'($urandom), 6'($urandom), 1'b1);
				end else begin
					repeat ($urandom_range(1, 4))
						offer($urandom_range(1) ? CMD_READ : CMD_POLL, 8'($urandom),
							6'($urandom), 1'b1);
				end
			end
		end

		@(negedge clk) s_tvalid <= 1'b0;
		while (backlog != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && backlog == 0)
			$display("** command_line_assembler: PASSED **");
		else
			$display("** command_line_assembler: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
design/cla_pkg.sv
design/cla_ctrl.sv
design/cla_dpath.sv
design/command_line_assembler.sv
verif/command_line_assembler_checker.sv
verif/command_line_assembler_tb.sv
